[src/x86e_pkg.sv]
// ============================================================================
// x86e_pkg - shared types, constants and helpers for the x86-64 byte encoder
// Holds the opcode constants, the instruction and byte-plan records and the
// small functions that append bytes to a plan.
// ============================================================================
`timescale 1ns / 1ps

package x86e_pkg;

  // Field widths
  localparam int VREG_W   = 16;
  localparam int PREG_W   = 4;
  localparam int RCNT_W   = 5;
  localparam int USED_W   = 21;
  localparam int USED_XW  = USED_W + 1;
  localparam int CFG_IDX_W = 1;

  // Byte plan sizing: at most ten bytes per instruction
  localparam int MAX_BYTES = 10;
  localparam int LEN_W     = $clog2(MAX_BYTES + 1);
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int GRP_BYTES = 4;

  // Register mapping: five lanes, four bits per cycle
  localparam int NUM_MAP    = 5;
  localparam int MAP_BITS   = 4;
  localparam int MAP_STEPS  = VREG_W / MAP_BITS;
  localparam int STEP_W     = $clog2(MAP_STEPS);
  localparam int MAP_DST    = 0;
  localparam int MAP_R1     = 1;
  localparam int MAP_R2     = 2;
  localparam int MAP_BASE   = 3;
  localparam int MAP_IDX    = 4;

  // Request queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b1;
  localparam logic [RCNT_W-1:0]    REG_COUNT_RESET = 5'd16;
  localparam logic [RCNT_W-1:0]    REG_COUNT_MIN   = 5'd1;
  localparam logic [RCNT_W-1:0]    REG_COUNT_MAX   = 5'd16;
  localparam logic [USED_W-1:0]    CAPACITY_RESET  = 21'd1048576;

  // Operation and operand kind codes
  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_SUB   = 3'd1;
  localparam logic [2:0] FUNC_MUL   = 3'd2;
  localparam logic [2:0] FUNC_LOAD  = 3'd3;
  localparam logic [2:0] FUNC_STORE = 3'd4;
  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_IMM   = 2'd1;
  localparam logic [1:0] KIND_MEM   = 2'd2;
  localparam logic [1:0] MIN_OPS_BIN  = 2'd2;
  localparam logic [1:0] MIN_OPS_LOAD = 2'd1;

  // Operand sizes in bytes
  localparam logic [3:0] SIZE_1 = 4'd1;
  localparam logic [3:0] SIZE_2 = 4'd2;
  localparam logic [3:0] SIZE_4 = 4'd4;
  localparam logic [3:0] SIZE_8 = 4'd8;

  // Opcode bytes
  localparam logic [7:0] REX_BASE    = 8'h40;
  localparam logic [7:0] OP_ADD      = 8'h03;
  localparam logic [7:0] OP_SUB      = 8'h2B;
  localparam logic [7:0] OP_IMM8     = 8'h83;
  localparam logic [7:0] OP_IMM32    = 8'h81;
  localparam logic [7:0] OP_MOV_ST   = 8'h89;
  localparam logic [7:0] OP_MOV_LD   = 8'h8B;
  localparam logic [7:0] OP_IMUL_IMM = 8'h69;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_IMUL     = 8'hAF;
  localparam logic [7:0] PFX_OPSIZE  = 8'h66;
  localparam logic [7:0] OP_MOV8_LD  = 8'h8A;
  localparam logic [7:0] OP_MOV8_ST  = 8'h88;

  // ModRM fields
  localparam logic [1:0] MOD_IND    = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] EXT_ADD    = 3'd0;
  localparam logic [2:0] EXT_SUB    = 3'd5;
  localparam logic [2:0] RM_SIB     = 3'd4;

  typedef logic [VREG_W-1:0] vreg_t;
  typedef logic [PREG_W-1:0] preg_t;

  // One incoming request
  typedef struct packed {
    logic [2:0]         func;
    logic [1:0]         first_kind;
    logic [1:0]         second_kind;
    logic [1:0]         operand_count;
    logic [3:0]         operand_bytes;
    vreg_t              dest_vreg;
    vreg_t              first_vreg;
    vreg_t              second_vreg;
    logic signed [63:0] constant_value;
    vreg_t              base_vreg;
    vreg_t              index_vreg;
    logic [3:0]         scale_factor;
  } instr_t;

  // Planned bytes of one instruction; when grp is set the final four bytes
  // form a 32-bit field that is stored whole or not at all.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [LEN_W-1:0]          len;
    logic                      grp;
  } plan_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MAP,
    FR_PUSH
  } front_state_t;

  function automatic plan_t plan_put(plan_t p, logic [7:0] b);
    plan_t q;
    q = p;
    if (p.len < LEN_W'(MAX_BYTES)) begin
      q.data[p.len[IDX_W-1:0]] = b;
      q.len = p.len + LEN_W'(1);
    end
    return q;
  endfunction

  function automatic plan_t plan_put4(plan_t p, logic [31:0] v);
    plan_t q;
    q = p;
    for (int i = 0; i < GRP_BYTES; i++) begin
      q = plan_put(q, v[8*i +: 8]);
    end
    q.grp = 1'b1;
    return q;
  endfunction

  // REX prefix, appended only when some bit beyond the base is set
  function automatic plan_t plan_rex(plan_t p, logic w, preg_t r, preg_t x, preg_t b);
    logic [7:0] v;
    v = REX_BASE | {4'b0000, w, r[PREG_W-1], x[PREG_W-1], b[PREG_W-1]};
    if (v != REX_BASE) begin
      return plan_put(p, v);
    end
    return p;
  endfunction

  function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
    return {md, rg, rm};
  endfunction

endpackage

[src/x86e_regmap.sv]
// ============================================================================
// x86e_regmap - virtual to physical register mapping
// Five lanes of remainder logic reduce 16-bit register numbers modulo the
// register count, four dividend bits per cycle, most significant first.
// ============================================================================
`timescale 1ns / 1ps

module x86e_regmap import x86e_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  vreg_t [NUM_MAP-1:0]         vals,
  input  logic [RCNT_W-1:0]           divisor,
  output preg_t [NUM_MAP-1:0]         regs,
  output logic                        done
);

  vreg_t [NUM_MAP-1:0] shreg;
  preg_t [NUM_MAP-1:0] rem;
  preg_t [NUM_MAP-1:0] rem_next;
  logic [STEP_W-1:0]   step;
  logic                busy;

  // Restoring remainder steps, one per dividend bit
  always_comb begin
    logic [RCNT_W-1:0] r;
    for (int l = 0; l < NUM_MAP; l++) begin
      r = {1'b0, rem[l]};
      for (int j = 0; j < MAP_BITS; j++) begin
        r = {r[PREG_W-1:0], shreg[l][VREG_W-1-j]};
        if (r >= divisor) begin
          r = r - divisor;
        end
      end
      rem_next[l] = r[PREG_W-1:0];
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == STEP_W'(MAP_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(MAP_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Dividend shifters and partial remainders
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= vals;
      rem   <= '0;
    end else if (busy) begin
      for (int l = 0; l < NUM_MAP; l++) begin
        shreg[l] <= shreg[l] << MAP_BITS;
      end
      rem <= rem_next;
    end
  end

  assign regs = rem;

endmodule

[src/x86e_front.sv]
// ============================================================================
// x86e_front - request intake and byte planning
// Accepts one request, maps its registers, then builds the ordered list of
// candidate code bytes and pushes it into the plan queue.
// ============================================================================
`timescale 1ns / 1ps

module x86e_front import x86e_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  instr_t            in_item,
  input  logic [RCNT_W-1:0] reg_limit,
  input  logic              q_full,
  output logic              push,
  output plan_t             plan
);

  front_state_t        state;
  front_state_t        state_next;
  instr_t              it;
  vreg_t [NUM_MAP-1:0] map_vals;
  preg_t [NUM_MAP-1:0] map_regs;
  logic                map_done;
  logic                accept;

  assign accept = in_valid && in_ready;

  assign map_vals[MAP_DST]  = in_item.dest_vreg;
  assign map_vals[MAP_R1]   = in_item.first_vreg;
  assign map_vals[MAP_R2]   = in_item.second_vreg;
  assign map_vals[MAP_BASE] = in_item.base_vreg;
  assign map_vals[MAP_IDX]  = in_item.index_vreg;

  x86e_regmap u_regmap (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .vals    (map_vals),
    .divisor (reg_limit),
    .regs    (map_regs),
    .done    (map_done)
  );

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      it <= in_item;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (in_valid) state_next = FR_MAP;
      FR_MAP:  if (map_done) state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    case (state)
      FR_IDLE: in_ready = 1'b1;
      FR_PUSH: push = !q_full;
      default: ;
    endcase
  end

  // Byte plan for the captured request
  always_comb begin
    plan_t      p;
    logic       sz8;
    logic       sz4;
    logic       sz2;
    logic       sz1;
    logic       szw;
    logic       fit8;
    logic       fit32;
    logic       st;
    logic [2:0] ext;
    logic [1:0] sc;
    logic [7:0] op;
    logic [7:0] sib;
    preg_t      rd;
    preg_t      ra;
    preg_t      rb;
    preg_t      rg;
    preg_t      rbase;
    preg_t      ridx;

    p     = '0;
    rd    = map_regs[MAP_DST];
    ra    = map_regs[MAP_R1];
    rb    = map_regs[MAP_R2];
    rbase = map_regs[MAP_BASE];
    ridx  = map_regs[MAP_IDX];
    sz8   = it.operand_bytes == SIZE_8;
    sz4   = it.operand_bytes == SIZE_4;
    sz2   = it.operand_bytes == SIZE_2;
    sz1   = it.operand_bytes == SIZE_1;
    szw   = sz8 || sz4;
    // sign-extension checks for 8 and 32 bit fields
    fit8  = (&it.constant_value[63:7]) || !(|it.constant_value[63:7]);
    fit32 = (&it.constant_value[63:31]) || !(|it.constant_value[63:31]);
    st    = it.func == FUNC_STORE;
    ext   = (it.func == FUNC_ADD) ? EXT_ADD : EXT_SUB;
    rg    = st ? rb : rd;

    case (it.scale_factor)
      4'd2:    sc = 2'd1;
      4'd4:    sc = 2'd2;
      4'd8:    sc = 2'd3;
      default: sc = 2'd0;
    endcase
    sib = {sc, ridx[2:0], rbase[2:0]};

    case (it.func)
      FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
        if (it.operand_count >= MIN_OPS_BIN && it.first_kind == KIND_REG &&
            it.second_kind == KIND_REG) begin
          // move first source into destination when they differ
          if (rd != ra && szw) begin
            p = plan_rex(p, sz8, ra, preg_t'(0), rd);
            p = plan_put(p, OP_MOV_ST);
            p = plan_put(p, modrm(MOD_REG, ra[2:0], rd[2:0]));
          end
          if (szw) begin
            p = plan_rex(p, sz8, rd, preg_t'(0), rb);
            case (it.func)
              FUNC_ADD: p = plan_put(p, OP_ADD);
              FUNC_SUB: p = plan_put(p, OP_SUB);
              default: begin
                p = plan_put(p, OP_ESC);
                p = plan_put(p, OP_IMUL);
              end
            endcase
            p = plan_put(p, modrm(MOD_REG, rd[2:0], rb[2:0]));
          end
        end else if (it.operand_count >= MIN_OPS_BIN && it.first_kind == KIND_REG &&
                     it.second_kind == KIND_IMM) begin
          if (it.func == FUNC_MUL) begin
            if (szw) begin
              p = plan_rex(p, sz8, rd, preg_t'(0), ra);
              p = plan_put(p, OP_IMUL_IMM);
              p = plan_put(p, modrm(MOD_REG, rd[2:0], ra[2:0]));
              p = plan_put4(p, it.constant_value[31:0]);
            end
          end else begin
            if (rd != ra && szw) begin
              p = plan_rex(p, sz8, ra, preg_t'(0), rd);
              p = plan_put(p, OP_MOV_ST);
              p = plan_put(p, modrm(MOD_REG, ra[2:0], rd[2:0]));
            end
            if (szw) begin
              if (fit8) begin
                p = plan_rex(p, sz8, preg_t'(0), preg_t'(0), rd);
                p = plan_put(p, OP_IMM8);
                p = plan_put(p, modrm(MOD_REG, ext, rd[2:0]));
                p = plan_put(p, it.constant_value[7:0]);
              end else if (!sz8 || fit32) begin
                p = plan_rex(p, sz8, preg_t'(0), preg_t'(0), rd);
                p = plan_put(p, OP_IMM32);
                p = plan_put(p, modrm(MOD_REG, ext, rd[2:0]));
                p = plan_put4(p, it.constant_value[31:0]);
              end
            end
          end
        end
      end
      FUNC_LOAD, FUNC_STORE: begin
        if (it.operand_count >= (st ? MIN_OPS_BIN : MIN_OPS_LOAD)) begin
          if (it.first_kind == KIND_REG) begin
            // register-indirect form
            if (szw || sz2) begin
              if (sz2) begin
                p = plan_put(p, PFX_OPSIZE);
              end
              op = st ? OP_MOV_ST : OP_MOV_LD;
              p = plan_rex(p, sz8, rg, preg_t'(0), ra);
              p = plan_put(p, op);
              p = plan_put(p, modrm(MOD_IND, rg[2:0], ra[2:0]));
            end else if (sz1) begin
              op = st ? OP_MOV8_ST : OP_MOV8_LD;
              p = plan_rex(p, 1'b0, rg, preg_t'(0), ra);
              p = plan_put(p, op);
              p = plan_put(p, modrm(MOD_IND, rg[2:0], ra[2:0]));
            end
          end else if (it.first_kind == KIND_MEM && sz8) begin
            // base + index*scale + displacement
            op = st ? OP_MOV_ST : OP_MOV_LD;
            p = plan_rex(p, 1'b1, rg, ridx, rbase);
            p = plan_put(p, op);
            if (it.constant_value == '0) begin
              p = plan_put(p, modrm(MOD_IND, rg[2:0], RM_SIB));
              p = plan_put(p, sib);
            end else if (fit8) begin
              p = plan_put(p, modrm(MOD_DISP8, rg[2:0], RM_SIB));
              p = plan_put(p, sib);
              p = plan_put(p, it.constant_value[7:0]);
            end else begin
              p = plan_put(p, modrm(MOD_DISP32, rg[2:0], RM_SIB));
              p = plan_put(p, sib);
              p = plan_put4(p, it.constant_value[31:0]);
            end
          end
        end
      end
      default: ;
    endcase
    plan = p;
  end

`ifndef SYNTHESIS
  a_map_done_in_map: assert property (@(posedge clk) disable iff (rst)
    map_done |-> state == FR_MAP)
    else $error("register mapping finished outside the mapping state");
`endif

endmodule

[src/x86e_queue.sv]
// ============================================================================
// x86e_queue - plan queue between front and back
// Small register FIFO of byte plans so each side can stall on its own.
// ============================================================================
`timescale 1ns / 1ps

module x86e_queue import x86e_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  plan_t push_plan,
  output logic  full,
  input  logic  pop,
  output plan_t head,
  output logic  head_valid
);

  plan_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_plan;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |-> !push)
    else $error("plan pushed into a full queue");
`endif

endmodule

[src/x86e_back.sv]
// ============================================================================
// x86e_back - byte emitter
// Walks the head plan one byte per cycle when not stalled, applies the code
// store limit, marks the final emitted byte and drives the registered output.
// ============================================================================
`timescale 1ns / 1ps

module x86e_back import x86e_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  plan_t             head,
  input  logic              head_valid,
  output logic              pop,
  input  logic [USED_W-1:0] capacity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        code_byte,
  output logic              last
);

  logic [USED_W-1:0]  bytes_used;
  logic [LEN_W-1:0]   idx;
  logic [LEN_W-1:0]   idx_next;
  logic [LEN_W-1:0]   grp_base;
  logic [USED_XW-1:0] used_x;
  logic [USED_XW-1:0] cap_x;
  logic               emit;
  logic               next_emit;
  logic               slot_free;
  logic               load;

  assign used_x    = {1'b0, bytes_used};
  assign cap_x     = {1'b0, capacity};
  assign idx_next  = idx + LEN_W'(1);
  assign grp_base  = head.len - LEN_W'(GRP_BYTES);
  assign slot_free = !out_valid || out_ready;

  // Store-limit decisions for this byte and the one after it
  always_comb begin
    logic in_grp;
    logic grp_start;
    logic nxt_grp;
    logic nxt_start;
    in_grp    = head.grp && (idx > grp_base);
    grp_start = head.grp && (idx == grp_base);
    nxt_grp   = head.grp && (idx_next > grp_base);
    nxt_start = head.grp && (idx_next == grp_base);
    emit = (head.len != '0) &&
           (in_grp || (grp_start ? (used_x + USED_XW'(GRP_BYTES) <= cap_x)
                                 : (used_x < cap_x)));
    next_emit = (idx_next != head.len) &&
                (nxt_grp || (nxt_start ? (used_x + USED_XW'(GRP_BYTES + 1) <= cap_x)
                                       : (used_x + USED_XW'(1) < cap_x)));
  end

  assign load = head_valid && emit && slot_free;
  assign pop  = head_valid && (!emit || (slot_free && !next_emit));

  // Walk position and store count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      bytes_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx_next;
      end
      if (load) begin
        bytes_used <= bytes_used + USED_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output byte register
  always_ff @(posedge clk) begin
    if (load) begin
      code_byte <= head.data[idx[IDX_W-1:0]];
      last      <= !next_emit;
    end
  end

`ifndef SYNTHESIS
  a_used_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> bytes_used == $past(bytes_used))
    else $error("store count moved without an emitted byte");
  a_idx_in_plan: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.len != '0) |-> idx < head.len)
    else $error("byte position ran past the plan");
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("plan popped from an empty queue");
`endif

endmodule

[src/x86_instruction_byte_encoder.sv]
// ============================================================================
// x86_instruction_byte_encoder - x86-64 machine code emitter
// Turns one add/sub/multiply/load/store request into its x86-64 bytes.
// ============================================================================
// One request yields zero to ten code bytes on the output channel, one byte
// per cycle unless out_ready holds the output, with last set on the final
// byte; a request that encodes to nothing (or whose bytes are all dropped)
// produces no output. The front takes a request, reduces its five register
// numbers modulo the register count in a remainder unit that handles four
// bits per cycle, and queues the byte plan before it takes the next request;
// the back drains one byte per cycle, unless out_ready holds it, from a
// two-entry plan queue. Bytes are counted against the store capacity: a
// single byte is dropped once the count reaches capacity, and a 32-bit
// immediate or displacement is dropped whole unless all four bytes fit.
// Configuration (index 0 register count, index 1 store capacity) is to be
// written only when idle; the user is bound, the block does not enforce it.
`timescale 1ns / 1ps

module x86_instruction_byte_encoder import x86e_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           func,
  input  logic [1:0]           first_kind,
  input  logic [1:0]           second_kind,
  input  logic [1:0]           operand_count,
  input  logic [3:0]           operand_bytes,
  input  logic [VREG_W-1:0]    dest_vreg,
  input  logic [VREG_W-1:0]    first_vreg,
  input  logic [VREG_W-1:0]    second_vreg,
  input  logic signed [63:0]   constant_value,
  input  logic [VREG_W-1:0]    base_vreg,
  input  logic [VREG_W-1:0]    index_vreg,
  input  logic [3:0]           scale_factor,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           code_byte,
  output logic                 last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [USED_W-1:0]    cfg_data
);

  logic [RCNT_W-1:0] register_count;
  logic [RCNT_W-1:0] reg_limit;
  logic [USED_W-1:0] store_capacity;
  instr_t            in_item;
  plan_t             plan;
  plan_t             head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              head_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      register_count <= REG_COUNT_RESET;
      store_capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REG_COUNT: register_count <= cfg_data[RCNT_W-1:0];
        CFG_CAPACITY:  store_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Register count clamped to 1..16
  always_comb begin
    if (register_count == '0) begin
      reg_limit = REG_COUNT_MIN;
    end else if (register_count > REG_COUNT_MAX) begin
      reg_limit = REG_COUNT_MAX;
    end else begin
      reg_limit = register_count;
    end
  end

  // Request bundle
  always_comb begin
    in_item.func           = func;
    in_item.first_kind     = first_kind;
    in_item.second_kind    = second_kind;
    in_item.operand_count  = operand_count;
    in_item.operand_bytes  = operand_bytes;
    in_item.dest_vreg      = dest_vreg;
    in_item.first_vreg     = first_vreg;
    in_item.second_vreg    = second_vreg;
    in_item.constant_value = constant_value;
    in_item.base_vreg      = base_vreg;
    in_item.index_vreg     = index_vreg;
    in_item.scale_factor   = scale_factor;
  end

  x86e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .reg_limit (reg_limit),
    .q_full    (q_full),
    .push      (push),
    .plan      (plan)
  );

  x86e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_plan  (plan),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  x86e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .capacity   (store_capacity),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_byte  (code_byte),
    .last       (last)
  );

endmodule
